// ===== rtl/embedding_row_sgd_with_norm_clip_macros.svh =====
// Assertion macros for the embedding row SGD block.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef EMBEDDING_ROW_SGD_WITH_NORM_CLIP_MACROS_SVH
`define EMBEDDING_ROW_SGD_WITH_NORM_CLIP_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ERSGD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define ERSGD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/ersgd_pkg.sv =====
// Shared types and constants of the embedding row SGD block.
// No dependencies; used by ersgd_divsqrt and the top level.
`timescale 1ns / 1ps
package ersgd_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int DIM_DEF = 64;
    localparam int MAX_ELEMS = 64;

    localparam logic [31:0] CLIP_Q29 = 32'd26843546;
    localparam logic [63:0] CLIP_SQ = 64'(CLIP_Q29) * 64'(CLIP_Q29);

    localparam logic [5:0] SLOT_STEPS = 6'd16;
    localparam logic [5:0] SQRT_STEPS = 6'd32;
    localparam logic [5:0] SCALE_STEPS = 6'd57;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_GRAD = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_SLOTS = 2'd0,
        CFG_DIMS = 2'd1,
        CFG_RATE = 2'd2,
        CFG_LEARN = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SLOT,
        S_LK_RD,
        S_LK_CAP,
        S_LK_OUT,
        S_GRAD,
        S_SQ,
        S_UPD,
        S_SQRT,
        S_DIV,
        S_FAC,
        S_FAC_W,
        S_EL_RD,
        S_EL_MUL,
        S_EL_WR
    } state_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
        logic [5:0] steps;
    } ds_req_t;

endpackage

// ===== rtl/ersgd_mul.sv =====
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on nothing.
`timescale 1ns / 1ps
module ersgd_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/ersgd_divsqrt.sv =====
// Shared shift and subtract unit: restoring division or square root, one bit per cycle.
// Depends on ersgd_pkg.
`timescale 1ns / 1ps
module ersgd_divsqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  ersgd_pkg::ds_req_t req,
    input  logic [63:0]        num,
    input  logic [31:0]        den,
    output logic               done,
    output logic [31:0]        quo,
    output logic [33:0]        rem
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        sqrt_reg;
    logic [63:0] n_reg;
    logic [33:0] r_reg;
    logic [31:0] q_reg;
    logic [31:0] den_reg;
    logic [33:0] trial;
    logic [33:0] sub_b;
    logic [34:0] diff;
    logic        ge;

    always_comb begin
        trial = sqrt_reg ? {r_reg[31:0], n_reg[63:62]} : {r_reg[32:0], n_reg[63]};
        sub_b = sqrt_reg ? {q_reg, 2'b01} : {2'b00, den_reg};
        diff = {1'b0, trial} - {1'b0, sub_b};
        ge = !diff[34];
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next = req.steps;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            sqrt_reg <= req.is_sqrt;
            n_reg <= num;
            den_reg <= den;
            r_reg <= '0;
            q_reg <= '0;
        end else if (busy_reg) begin
            r_reg <= ge ? diff[33:0] : trial;
            q_reg <= {q_reg[30:0], ge};
            n_reg <= sqrt_reg ? {n_reg[61:0], 2'b00} : {n_reg[62:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quo = q_reg;
    assign rem = r_reg;

endmodule

// ===== rtl/embedding_row_sgd_with_norm_clip.sv =====
// Embedding table with per-row SGD update and gradient norm clipping.
// Items enter on s_valid/s_ready; lookup elements leave on m_valid/m_ready.
// One item is in the block at a time and s_ready is low while it is worked on.
// Every item first reduces its slot in the shared divider.
// A write or mode 3 item then ends; a gradient item in range is then stored and its square added to the sum.
// A lookup then walks the row through S_LK_RD, S_LK_CAP and S_LK_OUT per element;
// a low m_ready holds the element in the output register and the walk waits.
// The gradient item marked final runs the row update when learning is on and
// the rate is not zero: a square root and a division when the norm is clipped,
// then a read, multiply and write for each buffered element, skipping the
// others, on the shared divider and the shared multiplier.
// Configuration is written on cfg_wr_en with cfg_index and cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce this.
// Reset returns the registers to 16 rows, 64 elements, rate zero and learning
// on, and clears the gradient buffer marks and the squared sum. The table
// itself is not cleared and must be written before it is read.
// Depends on ersgd_pkg, ersgd_mul, ersgd_divsqrt and the macro header.
`timescale 1ns / 1ps
`include "embedding_row_sgd_with_norm_clip_macros.svh"
module embedding_row_sgd_with_norm_clip #(
    parameter int NUM_SLOTS = ersgd_pkg::NUM_SLOTS_DEF,
    parameter int DIM = ersgd_pkg::DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [15:0] s_slot,
    input  logic [5:0]         s_element_index,
    input  logic signed [31:0] s_data_value,
    input  logic               s_final_element,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_row_value,
    output logic [5:0]         m_row_index,
    output logic               m_row_end
);

    localparam int RW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TBL_DEPTH = NUM_SLOTS * DIM;
    localparam int AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int DIM_CAP = (DIM < ersgd_pkg::MAX_ELEMS) ? DIM : ersgd_pkg::MAX_ELEMS;
    localparam int SLOT_CAP = (NUM_SLOTS < 31) ? NUM_SLOTS : 31;

    ersgd_pkg::state_t state_reg, state_next;

    logic [4:0]  slots_reg;
    logic [6:0]  dims_reg;
    logic [15:0] rate_reg;
    logic        learn_reg;

    logic [1:0]  mode_reg;
    logic [15:0] slot_reg;
    logic [5:0]  idx_reg;
    logic [31:0] data_reg;
    logic        final_reg;

    logic [RW-1:0] row_reg, row_next;
    logic [6:0]    i_reg, i_next;
    logic [63:0]   sum_reg, sum_next;
    logic [63:0]   present_reg, present_next;
    logic [31:0]   scale_reg, scale_next;
    logic [31:0]   factor_reg, factor_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_value_reg, m_value_next;
    logic [5:0]  m_index_reg, m_index_next;
    logic        m_end_reg, m_end_next;

    logic [31:0] tbl_mem [TBL_DEPTH];
    logic [31:0] grad_mem [ersgd_pkg::MAX_ELEMS];
    logic [31:0] tbl_rd_reg;
    logic [31:0] grad_rd_reg;
    logic        tbl_we, tbl_re, grad_we, grad_re;
    logic [AW-1:0] tbl_addr;
    logic [31:0] tbl_wdata;
    logic [6:0]  elem;

    ersgd_pkg::ds_req_t ds_req;
    logic [63:0] ds_num;
    logic [31:0] ds_den;
    logic        ds_done;
    logic [31:0] ds_quo;
    logic [33:0] ds_rem;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic [4:0]  slots_eff;
    logic [6:0]  dims_eff;
    logic [15:0] in_slot_mag;
    logic [4:0]  rem5;
    logic [4:0]  row_calc;
    logic [31:0] data_mag;
    logic [31:0] grad_mag;
    logic [64:0] sum_add;
    logic [63:0] fac_round;
    logic [63:0] d_round;
    logic [33:0] t_ext;
    logic [33:0] d_ext;
    logic [33:0] nv;
    logic [31:0] nv_sat;
    logic        s_fire;
    logic        idx_ok;

    ersgd_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    ersgd_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ds_req),
        .num     (ds_num),
        .den     (ds_den),
        .done    (ds_done),
        .quo     (ds_quo),
        .rem     (ds_rem)
    );

    always_comb begin
        if (slots_reg == 5'd0) begin
            slots_eff = 5'd1;
        end else if (slots_reg > 5'(SLOT_CAP)) begin
            slots_eff = 5'(SLOT_CAP);
        end else begin
            slots_eff = slots_reg;
        end
        if (dims_reg == 7'd0) begin
            dims_eff = 7'd1;
        end else if (dims_reg > 7'(DIM_CAP)) begin
            dims_eff = 7'(DIM_CAP);
        end else begin
            dims_eff = dims_reg;
        end
    end

    assign s_fire = s_valid && s_ready;
    assign s_ready = (state_reg == ersgd_pkg::S_IDLE);
    assign idx_ok = ({1'b0, idx_reg} < dims_eff);
    assign in_slot_mag = slot_reg[15] ? 16'(~slot_reg + 16'd1) : slot_reg;
    assign rem5 = ds_rem[4:0];
    assign row_calc = (slot_reg[15] && rem5 != 5'd0) ? (slots_eff - rem5) : rem5;
    assign data_mag = data_reg[31] ? 32'(~data_reg + 32'd1) : data_reg;
    assign grad_mag = grad_rd_reg[31] ? 32'(~grad_rd_reg + 32'd1) : grad_rd_reg;
    assign sum_add = {1'b0, sum_reg} + {1'b0, mul_p};
    assign fac_round = mul_p + 64'd32768;
    assign d_round = mul_p + 64'h0000_0000_4000_0000;
    assign t_ext = {{2{tbl_rd_reg[31]}}, tbl_rd_reg};
    assign d_ext = {1'b0, d_round[63:31]};
    assign nv = grad_rd_reg[31] ? (t_ext + d_ext) : (t_ext - d_ext);

    always_comb begin
        if (nv[33] && (nv[32:31] != 2'b11)) begin
            nv_sat = 32'h8000_0000;
        end else if (!nv[33] && (nv[32:31] != 2'b00)) begin
            nv_sat = 32'h7FFF_FFFF;
        end else begin
            nv_sat = nv[31:0];
        end
    end

    assign elem = (state_reg == ersgd_pkg::S_SLOT) ? {1'b0, idx_reg} : i_reg;
    assign tbl_addr = AW'(row_next) * AW'(DIM) + AW'(elem);

    always_comb begin
        state_next = state_reg;
        row_next = row_reg;
        i_next = i_reg;
        sum_next = sum_reg;
        present_next = present_reg;
        scale_next = scale_reg;
        factor_next = factor_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_index_next = m_index_reg;
        m_end_next = m_end_reg;
        tbl_we = 1'b0;
        tbl_re = 1'b0;
        tbl_wdata = data_reg;
        grad_we = 1'b0;
        grad_re = 1'b0;
        ds_req = '0;
        ds_num = {in_slot_mag, 48'd0};
        ds_den = 32'(slots_eff);
        mul_a = data_mag;
        mul_b = data_mag;
        case (state_reg)
            ersgd_pkg::S_IDLE: begin
                if (s_fire) begin
                    state_next = ersgd_pkg::S_START;
                end
            end
            ersgd_pkg::S_START: begin
                ds_req.start = 1'b1;
                ds_req.steps = ersgd_pkg::SLOT_STEPS;
                state_next = ersgd_pkg::S_SLOT;
            end
            ersgd_pkg::S_SLOT: begin
                if (ds_done) begin
                    row_next = RW'(row_calc);
                    i_next = '0;
                    case (mode_reg)
                        ersgd_pkg::MODE_LOOKUP: state_next = ersgd_pkg::S_LK_RD;
                        ersgd_pkg::MODE_GRAD: state_next = ersgd_pkg::S_GRAD;
                        ersgd_pkg::MODE_WRITE: begin
                            tbl_we = idx_ok;
                            state_next = ersgd_pkg::S_IDLE;
                        end
                        default: state_next = ersgd_pkg::S_IDLE;
                    endcase
                end
            end
            ersgd_pkg::S_LK_RD: begin
                tbl_re = 1'b1;
                state_next = ersgd_pkg::S_LK_CAP;
            end
            ersgd_pkg::S_LK_CAP: begin
                m_valid_next = 1'b1;
                m_value_next = tbl_rd_reg;
                m_index_next = i_reg[5:0];
                m_end_next = (i_reg + 7'd1 == dims_eff);
                state_next = ersgd_pkg::S_LK_OUT;
            end
            ersgd_pkg::S_LK_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    i_next = i_reg + 7'd1;
                    state_next = m_end_reg ? ersgd_pkg::S_IDLE : ersgd_pkg::S_LK_RD;
                end
            end
            ersgd_pkg::S_GRAD: begin
                if (idx_ok) begin
                    grad_we = 1'b1;
                    present_next[idx_reg] = 1'b1;
                    state_next = ersgd_pkg::S_SQ;
                end else begin
                    state_next = final_reg ? ersgd_pkg::S_UPD : ersgd_pkg::S_IDLE;
                end
            end
            ersgd_pkg::S_SQ: begin
                sum_next = sum_add[64] ? '1 : sum_add[63:0];
                state_next = final_reg ? ersgd_pkg::S_UPD : ersgd_pkg::S_IDLE;
            end
            ersgd_pkg::S_UPD: begin
                if (!learn_reg || rate_reg == 16'd0) begin
                    sum_next = '0;
                    present_next = '0;
                    state_next = ersgd_pkg::S_IDLE;
                end else if (sum_reg > ersgd_pkg::CLIP_SQ) begin
                    ds_req.start = 1'b1;
                    ds_req.is_sqrt = 1'b1;
                    ds_req.steps = ersgd_pkg::SQRT_STEPS;
                    ds_num = sum_reg;
                    state_next = ersgd_pkg::S_SQRT;
                end else begin
                    scale_next = 32'h8000_0000;
                    state_next = ersgd_pkg::S_FAC;
                end
            end
            ersgd_pkg::S_SQRT: begin
                if (ds_done) begin
                    ds_req.start = 1'b1;
                    ds_req.steps = ersgd_pkg::SCALE_STEPS;
                    ds_num = ((64'(ersgd_pkg::CLIP_Q29) << 31) + 64'(ds_quo[31:1])) << 7;
                    ds_den = ds_quo;
                    state_next = ersgd_pkg::S_DIV;
                end
            end
            ersgd_pkg::S_DIV: begin
                if (ds_done) begin
                    scale_next = ds_quo;
                    state_next = ersgd_pkg::S_FAC;
                end
            end
            ersgd_pkg::S_FAC: begin
                mul_a = 32'(rate_reg);
                mul_b = scale_reg;
                state_next = ersgd_pkg::S_FAC_W;
            end
            ersgd_pkg::S_FAC_W: begin
                factor_next = fac_round[47:16];
                i_next = '0;
                state_next = ersgd_pkg::S_EL_RD;
            end
            ersgd_pkg::S_EL_RD: begin
                if (i_reg >= dims_eff) begin
                    sum_next = '0;
                    present_next = '0;
                    state_next = ersgd_pkg::S_IDLE;
                end else if (!present_reg[i_reg[5:0]]) begin
                    i_next = i_reg + 7'd1;
                end else begin
                    tbl_re = 1'b1;
                    grad_re = 1'b1;
                    state_next = ersgd_pkg::S_EL_MUL;
                end
            end
            ersgd_pkg::S_EL_MUL: begin
                mul_a = factor_reg;
                mul_b = grad_mag;
                state_next = ersgd_pkg::S_EL_WR;
            end
            ersgd_pkg::S_EL_WR: begin
                tbl_we = 1'b1;
                tbl_wdata = nv_sat;
                i_next = i_reg + 7'd1;
                state_next = ersgd_pkg::S_EL_RD;
            end
            default: state_next = ersgd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ersgd_pkg::S_IDLE;
            slots_reg <= 5'd16;
            dims_reg <= 7'd64;
            rate_reg <= 16'd0;
            learn_reg <= 1'b1;
            sum_reg <= '0;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg <= sum_next;
            present_reg <= present_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    ersgd_pkg::CFG_SLOTS: slots_reg <= cfg_wdata[4:0];
                    ersgd_pkg::CFG_DIMS: dims_reg <= cfg_wdata[6:0];
                    ersgd_pkg::CFG_RATE: rate_reg <= cfg_wdata;
                    ersgd_pkg::CFG_LEARN: learn_reg <= cfg_wdata[0];
                    default: learn_reg <= learn_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg <= s_mode;
            slot_reg <= s_slot;
            idx_reg <= s_element_index;
            data_reg <= s_data_value;
            final_reg <= s_final_element;
        end
        row_reg <= row_next;
        i_reg <= i_next;
        scale_reg <= scale_next;
        factor_reg <= factor_next;
        m_value_reg <= m_value_next;
        m_index_reg <= m_index_next;
        m_end_reg <= m_end_next;
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_addr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rd_reg <= tbl_mem[tbl_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (grad_we) begin
            grad_mem[idx_reg] <= data_reg;
        end
        if (grad_re) begin
            grad_rd_reg <= grad_mem[i_reg[5:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_row_value = m_value_reg;
    assign m_row_index = m_index_reg;
    assign m_row_end = m_end_reg;

    `ERSGD_ASSERT_NOW(a_no_accept_while_out, m_valid, !s_ready, "input taken during output")
    `ERSGD_ASSERT_NXT(a_busy_after_accept, s_fire, !s_ready, "block ready right after an item")
    `ERSGD_ASSERT_NXT(a_idle_after_row, m_valid && m_ready && m_row_end, s_ready, "no return to idle")
    `ERSGD_ASSERT_NOW(a_sum_clear_idle, s_ready && present_reg == 64'd0, sum_reg == 64'd0, "sum left")

endmodule
